// ===== hdl/slc_pkg.sv =====
// Shared types, constants and the brightness stretch table for the sector light block.
`timescale 1ns / 1ps

package slc_pkg;

    // Lighting model register
    localparam int               MODE_W          = 5;
    localparam logic [MODE_W-1:0] LIGHT_MODE_RESET = 5'd2;

    // Level thresholds of the dark light curve
    localparam logic [7:0] DARK_LEVEL_LIMIT = 8'd192;
    localparam logic [7:0] DARK_LEVEL_SPLIT = 8'd100;

    // Reciprocal of five: (x * 205) >> 10 is exact below 1024.
    localparam logic [7:0] RECIP_FIVE       = 8'd205;
    localparam int         RECIP_FIVE_SHIFT = 10;

    // Stream word widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    // How a level is treated on its way through the level pipeline
    typedef enum logic [1:0] {
        PATH_PLAIN = 2'd0,
        PATH_HIGH  = 2'd1,
        PATH_LOW   = 2'd2
    } path_t;

    // One input word, unpacked
    typedef struct packed {
        logic [7:0]        level_in;
        logic signed [8:0] rel_light;
        logic              is_weapon;
        logic [7:0]        blend_amount;
        logic [2:0][7:0]   tint;
    } item_t;

    // Word handed from the level pipeline to the colour pipeline
    typedef struct packed {
        logic [7:0]      level;
        logic [7:0]      blend_amount;
        logic [2:0][7:0] tint;
    } lvl_item_t;

    // One result word
    typedef struct packed {
        logic [7:0]      level_out;
        logic [2:0][7:0] lit;
    } result_t;

    typedef logic [7:0] stretch_lut_t [256];

    // Stretched level round(192 - (192 - l) * 1.87), ties to even, for 100 < l < 192.
    function automatic stretch_lut_t build_stretch();
        stretch_lut_t lut;
        int           n;
        int           q;
        int           r;
        for (int i = 0; i < 256; i++) begin
            lut[i] = 8'd0;
            if (i > 100 && i < 192) begin
                n = 19200 - (192 - i) * 187;
                q = n / 100;
                r = n % 100;
                if (r > 50 || (r == 50 && (q % 2) == 1)) begin
                    q = q + 1;
                end
                lut[i] = 8'(q);
            end
        end
        return lut;
    endfunction

    localparam stretch_lut_t STRETCH_LUT = build_stretch();

endpackage

// ===== hdl/slc_level.sv =====
// Three stage pipeline that turns the sector level and offset into the hardware light level.
`timescale 1ns / 1ps

module slc_level (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               dark_mode,
    input  logic               sw_mode,
    input  logic               in_valid,
    output logic               in_ready,
    input  slc_pkg::item_t     in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output slc_pkg::lvl_item_t out_item
);
    import slc_pkg::*;

    logic en_a;
    logic en_b;
    logic en_c;

    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;

    // Stage A registers
    path_t             a_path_reg;
    logic              a_zero_reg;
    logic signed [9:0] a_sum_reg;
    lvl_item_t         a_item_reg;

    // Stage B registers
    path_t             b_path_reg;
    logic              b_zero_reg;
    logic              b_neg_reg;
    logic signed [9:0] b_sum_reg;
    logic [16:0]       b_prod_reg;
    lvl_item_t         b_item_reg;

    // Stage C register
    lvl_item_t         c_item_reg;

    // Stage A logic
    logic              a_dark;
    logic              a_apply;
    path_t             a_path_next;
    logic [7:0]        a_base;
    logic signed [9:0] a_sum_next;

    // Stage B logic
    logic signed [9:0] b_diff;
    logic signed [9:0] b_mag_wide;
    logic              b_neg_next;
    logic [8:0]        b_mag;

    // Stage C logic
    logic [6:0]        c_quot;
    logic signed [9:0] c_res;
    logic [7:0]        c_level;

    // Each stage moves when it is empty or the stage after it moves.
    assign en_c     = !c_valid_reg || out_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // Stage A: pick the curve, look up the stretched level and add the offset.
    always_comb begin
        a_dark  = dark_mode || (sw_mode && (in_item.blend_amount != 8'd0));
        a_apply = a_dark && (in_item.level_in < DARK_LEVEL_LIMIT) && !in_item.is_weapon;
        if (!a_apply) begin
            a_path_next = PATH_PLAIN;
        end else if (in_item.level_in > DARK_LEVEL_SPLIT) begin
            a_path_next = PATH_HIGH;
        end else begin
            a_path_next = PATH_LOW;
        end
        a_base     = (a_path_next == PATH_HIGH) ? STRETCH_LUT[in_item.level_in]
                                                : in_item.level_in;
        a_sum_next = $signed({2'b00, a_base}) + 10'(in_item.rel_light);
    end

    // Stage B: form the dividend magnitude and multiply by the reciprocal of five.
    always_comb begin
        b_diff     = 10'sd20 - a_sum_reg;
        b_neg_next = 1'b0;
        b_mag_wide = 10'sd0;
        case (a_path_reg)
            PATH_HIGH: begin
                b_neg_next = a_sum_reg < 10'sd20;
                b_mag_wide = b_diff;
            end
            PATH_LOW: begin
                b_neg_next = a_sum_reg < 10'sd0;
                b_mag_wide = b_neg_next ? -a_sum_reg : a_sum_reg;
            end
            default: begin
                b_neg_next = 1'b0;
                b_mag_wide = 10'sd0;
            end
        endcase
        b_mag = b_mag_wide[8:0];
    end

    // Stage C: finish the division, apply the curve and clamp to a byte.
    always_comb begin
        c_quot = b_prod_reg[16:RECIP_FIVE_SHIFT];
        case (b_path_reg)
            PATH_HIGH: begin
                c_res = b_neg_reg ? (10'sd20 - $signed({3'b000, c_quot})) : b_sum_reg;
            end
            PATH_LOW: begin
                c_res = b_neg_reg ? -$signed({3'b000, c_quot}) : $signed({3'b000, c_quot});
            end
            default: begin
                c_res = b_sum_reg;
            end
        endcase
        if (b_zero_reg || c_res < 10'sd0) begin
            c_level = 8'd0;
        end else if (c_res > 10'sd255) begin
            c_level = 8'd255;
        end else begin
            c_level = c_res[7:0];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (en_a) a_valid_reg <= in_valid;
            if (en_b) b_valid_reg <= a_valid_reg;
            if (en_c) c_valid_reg <= b_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en_a && in_valid) begin
            a_path_reg              <= a_path_next;
            a_zero_reg              <= in_item.level_in == 8'd0;
            a_sum_reg               <= a_sum_next;
            a_item_reg.level        <= in_item.level_in;
            a_item_reg.blend_amount <= in_item.blend_amount;
            a_item_reg.tint         <= in_item.tint;
        end
        if (en_b && a_valid_reg) begin
            b_path_reg <= a_path_reg;
            b_zero_reg <= a_zero_reg;
            b_neg_reg  <= b_neg_next;
            b_sum_reg  <= a_sum_reg;
            b_prod_reg <= b_mag * RECIP_FIVE;
            b_item_reg <= a_item_reg;
        end
        if (en_c && b_valid_reg) begin
            c_item_reg.level        <= c_level;
            c_item_reg.blend_amount <= b_item_reg.blend_amount;
            c_item_reg.tint         <= b_item_reg.tint;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

// ===== hdl/slc_color.sv =====
// Two stage pipeline that blends or scales the light colour by the adjusted level, or passes it through.
`timescale 1ns / 1ps

module slc_color (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               sw_mode,
    input  logic               in_valid,
    output logic               in_ready,
    input  slc_pkg::lvl_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output slc_pkg::result_t   out_result
);
    import slc_pkg::*;

    logic en_d;
    logic en_e;

    logic d_valid_reg;
    logic e_valid_reg;

    // Stage D registers
    logic [2:0][15:0] d_num_reg;
    logic [2:0][7:0]  d_tint_reg;
    logic [7:0]       d_level_reg;
    logic             d_pass_reg;

    // Stage E register
    result_t          e_result_reg;

    logic [7:0]       d_inv_blend;
    logic [2:0][15:0] d_num_next;
    logic [2:0][15:0] d_mix;
    logic [2:0][15:0] e_round;
    result_t          e_result_next;

    assign en_e     = !e_valid_reg || out_ready;
    assign en_d     = !d_valid_reg || en_e;
    assign in_ready = en_d;

    // Stage D: per channel numerator, either c * L or the blend mix (at most 255 * 255).
    always_comb begin
        d_inv_blend = 8'd255 - in_item.blend_amount;
        for (int ch = 0; ch < 3; ch++) begin
            if (in_item.blend_amount == 8'd0) begin
                d_mix[ch] = 16'(in_item.tint[ch]) * 16'(in_item.level);
            end else begin
                d_mix[ch] = 16'(in_item.level) * 16'(d_inv_blend)
                          + 16'(in_item.tint[ch]) * 16'(in_item.blend_amount);
            end
            d_num_next[ch] = d_mix[ch];
        end
    end

    // Stage E: divide by 255 with (x + (x >> 8) + 1) >> 8, exact for x up to 255 * 255.
    always_comb begin
        e_result_next.level_out = d_level_reg;
        for (int ch = 0; ch < 3; ch++) begin
            e_round[ch] = d_num_reg[ch] + 16'(d_num_reg[ch][15:8]) + 16'd1;
            e_result_next.lit[ch] = d_pass_reg ? d_tint_reg[ch] : e_round[ch][15:8];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (en_d) d_valid_reg <= in_valid;
            if (en_e) e_valid_reg <= d_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en_d && in_valid) begin
            d_num_reg   <= d_num_next;
            d_tint_reg  <= in_item.tint;
            d_level_reg <= in_item.level;
            d_pass_reg  <= sw_mode && (in_item.blend_amount == 8'd0);
        end
        if (en_e && d_valid_reg) begin
            e_result_reg <= e_result_next;
        end
    end

    assign out_valid  = e_valid_reg;
    assign out_result = e_result_reg;

endmodule

// ===== hdl/sector_light_level_and_color_top.sv =====
// Top level of the sector light level and colour block: stream ports and mode register.
//
// Usage:
//   The slave stream carries one item per word: level, relative offset, blend
//   factor and RGB light colour in s_tdata, and the weapon flag in s_tuser.
//   The master stream returns one word per item: adjusted level and lit RGB.
//   Words are taken on s_tvalid & s_tready and delivered on m_tvalid & m_tready.
//   The lighting model register is written through cfg_we / cfg_wdata and
//   should only change while no word is in flight.
//   Three stages compute the level curve (table lookup and offset add,
//   reciprocal multiply, clamp) and two the colour (8x8 multiplies, divide
//   by 255). Throughput is one word per cycle while m_tready stays high;
//   each stage holds its own valid bit, so bubbles are squeezed out.
//   When the receiver stalls the pipeline fills up and then s_tready drops;
//   no word is lost or repeated. Synchronous reset empties the pipeline and
//   sets the lighting model to 2 (dark light mode).
`timescale 1ns / 1ps

module sector_light_level_and_color_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [slc_pkg::MODE_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // level_in[7:0], rel_light[16:8], blend_amount[24:17], tint_red[32:25],
    // tint_green[40:33], tint_blue[48:41], zero fill[55:49]
    input  logic [slc_pkg::S_TDATA_W-1:0] s_tdata,
    // is_weapon[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // level_out[7:0], lit_red[15:8], lit_green[23:16], lit_blue[31:24]
    output logic [slc_pkg::M_TDATA_W-1:0] m_tdata
);
    import slc_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic              dark_mode;
    logic              sw_mode;

    item_t             in_item;
    logic              lvl_valid;
    logic              lvl_ready;
    lvl_item_t         lvl_item;
    result_t           result;

    // Lighting model register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= LIGHT_MODE_RESET;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    assign dark_mode = mode_reg[1];
    assign sw_mode   = mode_reg >= MODE_W'(8);

    // Unpack the input word
    always_comb begin
        in_item.level_in     = s_tdata[7:0];
        in_item.rel_light    = $signed(s_tdata[16:8]);
        in_item.is_weapon    = s_tuser[0];
        in_item.blend_amount = s_tdata[24:17];
        in_item.tint[0]      = s_tdata[32:25];
        in_item.tint[1]      = s_tdata[40:33];
        in_item.tint[2]      = s_tdata[48:41];
    end

    slc_level u_level (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dark_mode (dark_mode),
        .sw_mode   (sw_mode),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (lvl_valid),
        .out_ready (lvl_ready),
        .out_item  (lvl_item)
    );

    slc_color u_color (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sw_mode    (sw_mode),
        .in_valid   (lvl_valid),
        .in_ready   (lvl_ready),
        .in_item    (lvl_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result word
    assign m_tdata = {result.lit[2], result.lit[1], result.lit[0], result.level_out};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the sector light level and colour block.
`timescale 1ns / 1ps

module tb_top;

    import slc_pkg::*;

    // Lighting models visited by the tests
    localparam logic [MODE_W-1:0] LM_STANDARD      = 5'd0;
    localparam logic [MODE_W-1:0] LM_BRIGHT        = 5'd1;
    localparam logic [MODE_W-1:0] LM_DARK          = 5'd2;
    localparam logic [MODE_W-1:0] LM_DARK_ALT      = 5'd3;
    localparam logic [MODE_W-1:0] LM_PLAIN_ALT     = 5'd4;
    localparam logic [MODE_W-1:0] LM_UNLISTED      = 5'd5;
    localparam logic [MODE_W-1:0] LM_SOFTWARE      = 5'd8;
    localparam logic [MODE_W-1:0] LM_SOFT_UNLISTED = 5'd9;
    localparam logic [MODE_W-1:0] LM_SOFT_VANILLA  = 5'd16;
    localparam logic [MODE_W-1:0] LM_ALL_ONES      = 5'd31;

    localparam int PIPE_LATENCY   = 5;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int RANDOM_PER_MODE = 75;
    localparam int REPORT_LIMIT   = 20;

    // One light request as it travels on the slave stream
    typedef struct packed {
        logic [7:0]        level;
        logic signed [8:0] rel;
        logic              weapon;
        logic [7:0]        blend;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } light_req_t;

    // One lit result as it comes back on the master stream
    typedef struct packed {
        logic [7:0] level;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } lit_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [MODE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // level_in, rel_light, blend_amount, tint_red, tint_green, tint_blue, zero fill
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // is_weapon
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // level_out, lit_red, lit_green, lit_blue
    logic [M_TDATA_W-1:0]  m_tdata;

    logic [MODE_W-1:0]     light_mode_shadow = LIGHT_MODE_RESET;
    lit_word_t             pending_lit[$];
    int                    mismatch_count = 0;
    int                    idle_cycles    = 0;
    bit                    sender_gaps    = 1'b1;
    bit                    sink_stalls    = 1'b1;
    bit                    sink_hold_req  = 1'b0;

    sector_light_level_and_color_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // One colour channel from the final level, the tint and the blend factor.
    function automatic logic [7:0] lit_channel(int level, int tint, int blend,
                                               logic [MODE_W-1:0] mode);
        int v;
        if (blend == 0) begin
            if (mode >= LM_SOFTWARE) begin
                v = tint;
            end else begin
                v = tint * level / 255;
            end
        end else begin
            v = (level * (255 - blend) + tint * blend) / 255;
        end
        return 8'(v);
    endfunction

    // Expected result word for one request under the given lighting model.
    function automatic lit_word_t predict_lit_word(light_req_t r, logic [MODE_W-1:0] mode);
        lit_word_t res;
        int        lvl;
        int        rel;
        int        blend;
        int        light;
        int        scaled;
        int        stretched;
        bit        dark;
        lvl   = r.level;
        rel   = r.rel;
        blend = r.blend;
        dark  = mode[1] || (mode >= LM_SOFTWARE && blend != 0);
        if (lvl == 0) begin
            light = 0;
        end else if (dark && lvl < 192 && !r.weapon) begin
            if (lvl > 100) begin
                // Stretch by 1.87 about 192, rounded to nearest with ties to even.
                scaled    = 19200 - (192 - lvl) * 187;
                stretched = scaled / 100;
                if (scaled % 100 > 50 || (scaled % 100 == 50 && stretched % 2 == 1)) begin
                    stretched = stretched + 1;
                end
                if (stretched + rel < 20) begin
                    light = 20 + (stretched + rel - 20) / 5;
                end else begin
                    light = stretched + rel;
                end
            end else begin
                light = (lvl + rel) / 5;
            end
        end else begin
            light = lvl + rel;
        end
        if (light < 0) light = 0;
        if (light > 255) light = 255;
        res.level = 8'(light);
        res.red   = lit_channel(light, r.red, blend, mode);
        res.green = lit_channel(light, r.green, blend, mode);
        res.blue  = lit_channel(light, r.blue, blend, mode);
        return res;
    endfunction

    function automatic light_req_t make_req(int level, int rel, bit weapon, int blend,
                                            int red, int green, int blue);
        light_req_t r;
        r.level  = 8'(level);
        r.rel    = 9'(rel);
        r.weapon = weapon;
        r.blend  = 8'(blend);
        r.red    = 8'(red);
        r.green  = 8'(green);
        r.blue   = 8'(blue);
        return r;
    endfunction

    // Random request, leaning towards the corners of the level curve.
    function automatic light_req_t random_req();
        light_req_t r;
        int         corner;
        r.level = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) begin
            corner = $urandom_range(0, 7);
            case (corner)
                0: r.level = 8'd0;
                1: r.level = 8'd100;
                2: r.level = 8'd101;
                3: r.level = 8'd142;
                4: r.level = 8'd191;
                5: r.level = 8'd192;
                6: r.level = 8'd255;
                default: r.level = 8'd1;
            endcase
        end
        r.rel    = 9'($urandom_range(0, 511));
        r.weapon = 1'($urandom_range(0, 1));
        r.blend  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        r.red    = 8'($urandom_range(0, 255));
        r.green  = 8'($urandom_range(0, 255));
        r.blue   = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
        return r;
    endfunction

    // Offer one word and return at the edge where it is taken.
    task automatic send_light_word(input light_req_t r);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.blue, r.green, r.red, r.blend, r.rel, r.level};
        s_tuser  <= r.weapon;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_lit.size() != 0) @(posedge aclk);
    endtask

    // Change the lighting model once the pipeline is empty.
    task automatic set_light_mode(input logic [MODE_W-1:0] mode);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we            <= 1'b0;
        light_mode_shadow  = mode;
    endtask

    task automatic send_random_words(input int count);
        for (int i = 0; i < count; i++) begin
            // Re-draw the idling style now and then so that quiet stretches occur.
            if (i % 25 == 0) begin
                sender_gaps = $urandom_range(0, 2) != 0;
                sink_stalls = $urandom_range(0, 2) != 0;
            end
            send_light_word(random_req());
        end
    endtask

    // Corners of the level curve under the reset model, then a few other models.
    task automatic test_directed_corners();
        send_light_word(make_req(0, 255, 0, 0, 255, 255, 255));
        send_light_word(make_req(142, 0, 0, 0, 255, 128, 0));
        send_light_word(make_req(101, -255, 0, 0, 10, 20, 30));
        send_light_word(make_req(191, 0, 0, 0, 255, 255, 255));
        send_light_word(make_req(192, 0, 0, 0, 255, 255, 255));
        send_light_word(make_req(100, 0, 0, 0, 200, 100, 50));
        send_light_word(make_req(100, -256, 0, 0, 200, 100, 50));
        send_light_word(make_req(150, 0, 1, 0, 77, 88, 99));
        send_light_word(make_req(255, 255, 0, 255, 0, 0, 0));
        send_light_word(make_req(1, -1, 0, 0, 255, 255, 255));
        send_light_word(make_req(120, -40, 0, 0, 255, 255, 255));
        send_light_word(make_req(110, -100, 0, 0, 255, 255, 255));
        set_light_mode(LM_STANDARD);
        send_light_word(make_req(200, -55, 0, 0, 255, 1, 128));
        send_light_word(make_req(50, 10, 0, 128, 0, 255, 64));
        set_light_mode(LM_SOFTWARE);
        send_light_word(make_req(150, 0, 0, 0, 12, 34, 56));
        send_light_word(make_req(150, 0, 0, 1, 12, 34, 56));
        send_light_word(make_req(255, 0, 0, 0, 255, 0, 170));
        set_light_mode(LM_ALL_ONES);
        send_light_word(make_req(142, 0, 0, 0, 255, 255, 255));
        send_light_word(make_req(80, 255, 0, 255, 1, 2, 3));
    endtask

    // Random words under each of the listed lighting models, the extremes among them.
    task automatic test_random_per_mode();
        logic [MODE_W-1:0] modes[10];
        modes = '{LM_STANDARD, LM_BRIGHT, LM_DARK, LM_DARK_ALT, LM_PLAIN_ALT,
                  LM_UNLISTED, LM_SOFTWARE, LM_SOFT_UNLISTED, LM_SOFT_VANILLA,
                  LM_ALL_ONES};
        foreach (modes[i]) begin
            set_light_mode(modes[i]);
            send_random_words(RANDOM_PER_MODE);
        end
    endtask

    // Receiver holds off for a long stretch while words keep coming.
    task automatic test_output_backpressure();
        set_light_mode(LM_DARK);
        sender_gaps   = 1'b0;
        sink_stalls   = 1'b0;
        sink_hold_req = 1'b1;
        repeat (2) @(posedge aclk);
        for (int i = 0; i < 40; i++) begin
            send_light_word(random_req());
        end
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Sender stops until every result is back, then carries on.
    task automatic test_sender_pause();
        for (int i = 0; i < 20; i++) begin
            send_light_word(random_req());
        end
        wait_results_drained();
        for (int i = 0; i < 20; i++) begin
            send_light_word(random_req());
        end
    endtask

    // Receiver: random stalls per word, or one long hold when a test asks.
    initial begin : sink_driver
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (sink_hold_req) begin
                stall         = LONG_HOLD;
                sink_hold_req = 1'b0;
            end else begin
                stall = sink_stalls ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid && !sink_hold_req) @(posedge aclk);
        end
    end

    // Predict each accepted word and compare each delivered word with the oldest prediction.
    always @(posedge aclk) begin : check_results
        light_req_t seen;
        lit_word_t  got;
        lit_word_t  want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                seen = {s_tdata[8:0] == 9'd0 ? s_tdata[7:0] : s_tdata[7:0],
                        s_tdata[16:8], s_tuser[0], s_tdata[24:17],
                        s_tdata[32:25], s_tdata[40:33], s_tdata[48:41]};
                pending_lit.push_back(predict_lit_word(seen, light_mode_shadow));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]};
                if (pending_lit.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result word, actual %h", $time, got);
                    end
                end else begin
                    want = pending_lit.pop_front();
                    if (got != want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            if (got.level != want.level)
                                $display("%0t: level_out expected %0d actual %0d",
                                         $time, want.level, got.level);
                            if (got.red != want.red)
                                $display("%0t: lit_red expected %0d actual %0d",
                                         $time, want.red, got.red);
                            if (got.green != want.green)
                                $display("%0t: lit_green expected %0d actual %0d",
                                         $time, want.green, got.green);
                            if (got.blue != want.blue)
                                $display("%0t: lit_blue expected %0d actual %0d",
                                         $time, want.blue, got.blue);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_random_per_mode();
        test_output_backpressure();
        test_sender_pause();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_lit.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sector_light_level_and_color_top.f =====
hdl/slc_pkg.sv
hdl/slc_level.sv
hdl/slc_color.sv
hdl/sector_light_level_and_color_top.sv
tb/tb_top.sv
